/* rtl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DATA_W              = 32;
  localparam int unsigned FILL_W              = 7;
  localparam int unsigned STACK_DEPTH_DEFAULT = 64;

  // operation carried in the kind field
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic take_item;  // capture the beat on the input side and execute it
    logic load_top;   // reload the top registers from the memory read data
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic single;     // exactly one entry held
  } stat_t;

endpackage

/* rtl/mts_ctrl.sv */
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer for the minimum-tracking stack: input handshake, memory read
// wait and result hold.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mts_pkg::stat_t     stat_i,
  output mts_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign take = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          // a pop leaving one or more entries needs the next top from memory
          if (kind_i == mts_pkg::KIND_POP && !stat_i.empty && !stat_i.single) begin
            state_d = S_READ;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign cmd_o.take_item = take;
  assign cmd_o.load_top  = (state_q == S_READ);

endmodule

/* rtl/mts_datapath.sv */
// ----------------------------------------------------------------------------
// mts_datapath
// Top-of-stack registers, fill count and the entry memory below the top.
// ----------------------------------------------------------------------------
module mts_datapath #(
  parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mts_pkg::cmd_t                       cmd_i,
  output mts_pkg::stat_t                      stat_o,
  input  logic                                kind_i,
  input  logic signed [mts_pkg::DATA_W-1:0]   value_i,
  output logic signed [mts_pkg::DATA_W-1:0]   top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]   min_value_o,
  output logic                                is_empty_o,
  output logic [mts_pkg::FILL_W-1:0]          fill_count_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

  typedef struct packed {
    logic signed [mts_pkg::DATA_W-1:0] val;
    logic signed [mts_pkg::DATA_W-1:0] min;
  } entry_t;

  // entries 0 .. count-2 live here; entry count-1 sits in the top registers
  entry_t mem [STACK_DEPTH];
  entry_t rd_q;

  logic [CNT_W-1:0]                  count_q, count_d;
  mts_pkg::status_e                  status_q, status_d;
  logic signed [mts_pkg::DATA_W-1:0] top_val_q, top_val_d;
  logic signed [mts_pkg::DATA_W-1:0] top_min_q, top_min_d;

  logic              empty, full, single;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;

  assign empty   = (count_q == '0);
  assign single  = (count_q == CNT_W'(1));
  assign full    = (count_q == CNT_W'(STACK_DEPTH));
  assign cnt_m1  = count_q - CNT_W'(1);
  assign cnt_m2  = count_q - CNT_W'(2);
  assign wr_addr = cnt_m1[ADDR_W-1:0];
  assign rd_addr = cnt_m2[ADDR_W-1:0];

  always_comb begin
    count_d   = count_q;
    status_d  = status_q;
    top_val_d = top_val_q;
    top_min_d = top_min_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    if (cmd_i.take_item) begin
      status_d = mts_pkg::ST_OK;
      if (kind_i == mts_pkg::KIND_PUSH) begin
        if (full) begin
          status_d = mts_pkg::ST_PUSH_FULL;
        end else begin
          // spill the old top below, keep the running minimum
          wr_en     = !empty;
          top_val_d = value_i;
          top_min_d = (!empty && (top_min_q < value_i)) ? top_min_q : value_i;
          count_d   = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = mts_pkg::ST_POP_EMPTY;
        end else begin
          rd_en   = !single;
          count_d = cnt_m1;
        end
      end
    end else if (cmd_i.load_top) begin
      top_val_d = rd_q.val;
      top_min_d = rd_q.min;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{val: top_val_q, min: top_min_q};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= mts_pkg::ST_OK;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q <= top_val_d;
    top_min_q <= top_min_d;
  end

  assign stat_o.empty  = empty;
  assign stat_o.single = single;

  assign top_value_o  = empty ? '0 : top_val_q;
  assign min_value_o  = empty ? '0 : top_min_q;
  assign is_empty_o   = empty;
  assign fill_count_o = mts_pkg::FILL_W'(count_q);
  assign status_o     = status_q;

endmodule

/* rtl/min_tracking_stack.sv */
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded LIFO of signed 32-bit values that reports the minimum held.
// ----------------------------------------------------------------------------
// Each input beat is a push of value_i (kind_i = 0) or a pop (kind_i = 1).
// Every beat yields exactly one result beat: top value, minimum of all held
// values (both zero when empty), empty flag, fill count (low 7 bits) and a
// status code (ok, pop on empty ignored, push on full ignored). Items run one
// at a time: a push or an ignored operation goes from acceptance straight to
// the result state, while a pop that leaves one or more entries first passes
// through a memory read state. That extra state waits on the registered
// read port of the entry memory, which refills the top-of-stack registers.
// Result fields hold steady while out_valid_o is high and out_stall_i holds
// them; no new input beat is taken until the result has left. The entry
// memory needs no clearing after reset: only live positions are ever read.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [mts_pkg::DATA_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mts_pkg::DATA_W-1:0]   top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]   min_value_o,
  output logic                                is_empty_o,
  output logic [mts_pkg::FILL_W-1:0]          fill_count_o,
  output logic [1:0]                          status_o
);

  mts_pkg::cmd_t  cmd;
  mts_pkg::stat_t stat;

  // sequencing: accept, optional memory wait, hold the result
  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // storage: top registers, running minimum, fill count, entry memory
  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .is_empty_o   (is_empty_o),
    .fill_count_o (fill_count_o),
    .status_o     (status_o)
  );

  // no new beat enters while a result is pending
  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  // the running minimum never exceeds the top value
  a_min_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_empty_o) |-> (min_value_o <= top_value_o))
    else $error("minimum above top value");

  // an ignored pop leaves the stack empty
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == mts_pkg::ST_POP_EMPTY) |-> is_empty_o)
    else $error("pop-on-empty reported with entries held");

  // an ignored push leaves the stack non-empty
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == mts_pkg::ST_PUSH_FULL) |-> !is_empty_o)
    else $error("push-on-full reported on an empty stack");

endmodule
